// ===== hw/rtl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and character codes for the CSV stream tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

	localparam int OUT_POS_W  = 16;
	localparam int FIFO_DEPTH = 4;

	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_QUOTE   = 8'h22;

	typedef enum logic [3:0] {
		ST_START    = 4'b0001,
		ST_QUOTED   = 4'b0010,
		ST_UNQUOTED = 4'b0100,
		ST_AFTER    = 4'b1000
	} parse_state_t;

	typedef enum logic [2:0] {
		EV_DATA    = 3'd0,
		EV_QUOTE   = 3'd1,
		EV_COMMA   = 3'd2,
		EV_NEWLINE = 3'd3,
		EV_END     = 3'd4
	} ev_t;

	typedef enum logic [2:0] {
		K_DATA         = 3'd0,
		K_FIELD        = 3'd1,
		K_FIELD_RECORD = 3'd2,
		K_RECORD       = 3'd3,
		K_NONE         = 3'd4,
		K_ERROR        = 3'd5
	} kind_t;

	typedef struct packed {
		parse_state_t ps;
		logic         rec;
	} tok_state_t;

	typedef struct packed {
		logic                 last;
		logic [OUT_POS_W-1:0] pos;
		logic [7:0]           data;
		kind_t                kind;
	} res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/csv_stream_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// csv_stream_tokenizer_core
// CSV byte tokenizer: data bytes, field and record ends, parse errors.
// ----------------------------------------------------------------------------
// The input byte is registered, then its results are written to the result
// queue. Throughput: one byte per cycle while the queue has room for two
// results; the single read port of the queue sends out one result at a time.
// Reset: arst_n clears the parse state, the held quote, the position count,
// the valid flag of the input register and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_stream_tokenizer_core #(
	parameter int POSITION_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic [0:0]  s_tuser,   // [0] end_of_input
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] position
	output logic [2:0]       m_tuser,   // [2:0] kind
	output logic             m_tlast    // last result of the input transaction
);
	import cst_pkg::*;

	logic                      valid_s1;
	logic [7:0]                byte_s1;
	logic                      eoi_s1;

	tok_state_t                st_q;
	logic [POSITION_WIDTH-1:0] pos_q;
	logic                      quote_pending_q;

	logic                      advance;
	logic                      has_room;
	logic                      not_empty;
	logic                      is_quote;
	logic                      skip_b;
	logic                      hold_b;
	logic                      b_en;
	ev_t                       ev_a;
	ev_t                       ev_b;
	logic [7:0]                ch_a;
	tok_state_t                st_a;
	tok_state_t                st_b;
	logic [POSITION_WIDTH-1:0] pos_a;
	logic [POSITION_WIDTH-1:0] pos_b;
	logic                      a_v;
	logic                      b_v;
	res_t                      res_a;
	res_t                      res_b;
	res_t                      wr0;
	res_t                      wr1;
	res_t                      rd;

	assign advance  = valid_s1 && has_room;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eoi_s1  <= s_tuser[0];
		end
	end

	// resolve the held quote first, then the current byte
	assign is_quote = !eoi_s1 && (byte_s1 == CH_QUOTE);
	assign ev_a     = is_quote ? EV_DATA : EV_QUOTE;
	assign ch_a     = is_quote ? CH_QUOTE : 8'h00;
	assign skip_b   = quote_pending_q && is_quote;
	assign hold_b   = !skip_b && is_quote && (st_a.ps != ST_START);
	assign b_en     = !skip_b && !hold_b;

	always_comb begin
		if (eoi_s1) ev_b = EV_END;
		else if (byte_s1 == CH_QUOTE) ev_b = EV_QUOTE;
		else if (byte_s1 == CH_COMMA) ev_b = EV_COMMA;
		else if (byte_s1 == CH_NEWLINE) ev_b = EV_NEWLINE;
		else ev_b = EV_DATA;
	end

	cst_token_step #(.POSITION_WIDTH(POSITION_WIDTH)) u_step_a (
		.en        (quote_pending_q),
		.st_in     (st_q),
		.pos_in    (pos_q),
		.ev        (ev_a),
		.ch        (ch_a),
		.st_out    (st_a),
		.pos_out   (pos_a),
		.res_valid (a_v),
		.res       (res_a)
	);

	cst_token_step #(.POSITION_WIDTH(POSITION_WIDTH)) u_step_b (
		.en        (b_en),
		.st_in     (st_a),
		.pos_in    (pos_a),
		.ev        (ev_b),
		.ch        (byte_s1),
		.st_out    (st_b),
		.pos_out   (pos_b),
		.res_valid (b_v),
		.res       (res_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.ps         <= ST_START;
			st_q.rec        <= 1'b0;
			pos_q           <= '0;
			quote_pending_q <= 1'b0;
		end else if (advance) begin
			st_q            <= st_b;
			pos_q           <= pos_b;
			quote_pending_q <= hold_b;
		end
	end

	always_comb begin
		wr0      = a_v ? res_a : res_b;
		wr0.last = !(a_v && b_v);
		wr1      = res_b;
		wr1.last = 1'b1;
	end

	cst_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (advance && (a_v || b_v)),
		.push1     (advance && a_v && b_v),
		.wr0       (wr0),
		.wr1       (wr1),
		.pop       (m_tready),
		.rd        (rd),
		.not_empty (not_empty),
		.has_room  (has_room)
	);

	assign m_tvalid = not_empty;
	assign m_tdata  = {rd.pos, rd.data};
	assign m_tuser  = rd.kind;
	assign m_tlast  = rd.last;

`ifndef SYNTH
	a_pending_not_start: assert property (@(posedge clk) disable iff (!arst_n)
		quote_pending_q |-> (st_q.ps != ST_START))
		else $error("held quote in start state");

	a_rec_has_pos: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.rec |-> (pos_q != '0))
		else $error("record open with zero position");

	a_eoi_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eoi_s1) |=> !quote_pending_q)
		else $error("quote held past end of input");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/cst_token_step.sv =====
// ----------------------------------------------------------------------------
// cst_token_step
// One token through the parse state machine: next state, position, result.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_token_step #(
	parameter int POSITION_WIDTH = 16
) (
	input  wire logic                      en,
	input  wire cst_pkg::tok_state_t       st_in,
	input  wire logic [POSITION_WIDTH-1:0] pos_in,
	input  wire cst_pkg::ev_t              ev,
	input  wire logic [7:0]                ch,
	output cst_pkg::tok_state_t            st_out,
	output logic [POSITION_WIDTH-1:0]      pos_out,
	output logic                           res_valid,
	output cst_pkg::res_t                  res
);
	import cst_pkg::*;

	logic [POSITION_WIDTH-1:0] pos_inc;
	logic                      emit;
	logic                      restart;
	kind_t                     kind;
	logic [7:0]                data;
	tok_state_t                st_nx;

	assign pos_inc = (pos_in != {POSITION_WIDTH{1'b1}}) ? pos_in + 1'b1 : pos_in;

	always_comb begin
		emit    = 1'b0;
		restart = 1'b0;
		kind    = K_DATA;
		data    = 8'h00;
		st_nx   = st_in;
		unique case (st_in.ps)
			ST_QUOTED: begin
				case (ev)
					EV_QUOTE: st_nx.ps = ST_AFTER;
					EV_END: begin
						emit    = 1'b1;
						kind    = K_ERROR;
						restart = 1'b1;
					end
					default: begin
						emit = 1'b1;
						data = ch;
					end
				endcase
			end
			ST_UNQUOTED: begin
				case (ev)
					EV_DATA: begin
						emit = 1'b1;
						data = ch;
					end
					EV_QUOTE: begin
						emit    = 1'b1;
						kind    = K_ERROR;
						restart = 1'b1;
					end
					EV_COMMA: begin
						emit      = 1'b1;
						kind      = K_FIELD;
						st_nx.ps  = ST_START;
						st_nx.rec = 1'b1;
					end
					default: begin
						emit    = 1'b1;
						kind    = K_FIELD_RECORD;
						restart = 1'b1;
					end
				endcase
			end
			ST_AFTER: begin
				case (ev)
					EV_DATA, EV_QUOTE: begin
						emit    = 1'b1;
						kind    = K_ERROR;
						restart = 1'b1;
					end
					EV_COMMA: begin
						emit      = 1'b1;
						kind      = K_FIELD;
						st_nx.ps  = ST_START;
						st_nx.rec = 1'b1;
					end
					default: begin
						emit    = 1'b1;
						kind    = K_FIELD_RECORD;
						restart = 1'b1;
					end
				endcase
			end
			default: begin
				case (ev)
					EV_DATA: begin
						emit     = 1'b1;
						data     = ch;
						st_nx.ps = ST_UNQUOTED;
					end
					EV_QUOTE: st_nx.ps = ST_QUOTED;
					EV_COMMA: begin
						emit      = 1'b1;
						kind      = K_FIELD;
						st_nx.rec = 1'b1;
					end
					EV_NEWLINE: begin
						emit    = 1'b1;
						kind    = K_FIELD_RECORD;
						restart = 1'b1;
					end
					default: begin
						emit    = 1'b1;
						kind    = st_in.rec ? K_RECORD : K_NONE;
						restart = 1'b1;
					end
				endcase
			end
		endcase
	end

	always_comb begin
		if (!en) begin
			st_out  = st_in;
			pos_out = pos_in;
		end else if (restart) begin
			st_out.ps  = ST_START;
			st_out.rec = 1'b0;
			pos_out    = '0;
		end else begin
			st_out  = st_nx;
			pos_out = pos_inc;
		end
	end

	assign res_valid = en && emit;
	assign res.last  = 1'b0;
	assign res.pos   = OUT_POS_W'(pos_inc);
	assign res.data  = data;
	assign res.kind  = kind;

endmodule

`default_nettype wire

// ===== hw/rtl/cst_out_fifo.sv =====
// ----------------------------------------------------------------------------
// cst_out_fifo
// Small result queue: up to two entries written and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_out_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push0,
	input  wire logic          push1,
	input  wire cst_pkg::res_t wr0,
	input  wire cst_pkg::res_t wr1,
	input  wire logic          pop,
	output cst_pkg::res_t      rd,
	output logic               not_empty,
	output logic               has_room
);
	import cst_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	res_t             entry_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_ptr_p1;
	logic             do_pop;

	assign wr_ptr_p1 = wr_ptr_q + 1'b1;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push0) entry_q[wr_ptr_q] <= wr0;
		if (push1) entry_q[wr_ptr_p1] <= wr1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push0) + PTR_W'(push1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(do_pop);
		end
	end

	assign rd        = entry_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign has_room  = (count_q <= CNT_W'(FIFO_DEPTH - 2));

endmodule

`default_nettype wire

// ===== dv/csv_stream_tokenizer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csv_stream_tokenizer_checker
// Watches both stream channels of the CSV tokenizer, predicts the results of
// every accepted input byte and compares them in order with the results the
// block delivers.
// ----------------------------------------------------------------------------

module csv_stream_tokenizer_checker #(
	parameter int POSITION_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic [0:0]  s_tuser,   // [0] end_of_input
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] position
	input  logic [2:0]  m_tuser,   // [2:0] kind
	input  logic        m_tlast,
	output int          mismatch_count,
	output int          outstanding
);
	import cst_pkg::*;

	parse_state_t              pstate;
	logic                      held_quote;
	logic                      rec_open;
	logic [POSITION_WIDTH-1:0] tok_pos;

	res_t step_out[2];
	int   step_n;
	res_t pending_tokens[$];

	task automatic emit(input kind_t k, input logic [7:0] c);
		step_out[step_n] = '{last: 1'b0, pos: OUT_POS_W'(tok_pos), data: c, kind: k};
		step_n++;
	endtask

	task automatic restart_record();
		pstate   = ST_START;
		rec_open = 1'b0;
		tok_pos  = '0;
	endtask

	task automatic take_token(input ev_t ev, input logic [7:0] c);
		if (tok_pos != '1)
			tok_pos++;
		case (pstate)
			ST_START: begin
				case (ev)
					EV_DATA: begin
						pstate = ST_UNQUOTED;
						emit(K_DATA, c);
					end
					EV_QUOTE: pstate = ST_QUOTED;
					EV_COMMA: begin
						rec_open = 1'b1;
						emit(K_FIELD, 8'h00);
					end
					EV_NEWLINE: begin
						emit(K_FIELD_RECORD, 8'h00);
						restart_record();
					end
					default: begin
						emit(rec_open ? K_RECORD : K_NONE, 8'h00);
						restart_record();
					end
				endcase
			end
			ST_QUOTED: begin
				if (ev == EV_QUOTE) begin
					pstate = ST_AFTER;
				end else if (ev == EV_END) begin
					emit(K_ERROR, 8'h00);
					restart_record();
				end else begin
					emit(K_DATA, c);
				end
			end
			ST_UNQUOTED: begin
				if (ev == EV_DATA) begin
					emit(K_DATA, c);
				end else if (ev == EV_QUOTE) begin
					emit(K_ERROR, 8'h00);
					restart_record();
				end else if (ev == EV_COMMA) begin
					pstate   = ST_START;
					rec_open = 1'b1;
					emit(K_FIELD, 8'h00);
				end else begin
					emit(K_FIELD_RECORD, 8'h00);
					restart_record();
				end
			end
			default: begin
				if (ev == EV_DATA || ev == EV_QUOTE) begin
					emit(K_ERROR, 8'h00);
					restart_record();
				end else if (ev == EV_COMMA) begin
					pstate   = ST_START;
					rec_open = 1'b1;
					emit(K_FIELD, 8'h00);
				end else begin
					emit(K_FIELD_RECORD, 8'h00);
					restart_record();
				end
			end
		endcase
	endtask

	task automatic tokenize_byte(input logic [7:0] b, input logic eoi);
		logic paired;
		paired = 1'b0;
		step_n = 0;
		if (held_quote) begin
			held_quote = 1'b0;
			if (!eoi && b == CH_QUOTE) begin
				take_token(EV_DATA, CH_QUOTE);
				paired = 1'b1;
			end else begin
				take_token(EV_QUOTE, 8'h00);
			end
		end
		if (!paired) begin
			if (eoi)
				take_token(EV_END, 8'h00);
			else if (b == CH_QUOTE && pstate != ST_START)
				held_quote = 1'b1;
			else if (b == CH_QUOTE)
				take_token(EV_QUOTE, 8'h00);
			else if (b == CH_COMMA)
				take_token(EV_COMMA, b);
			else if (b == CH_NEWLINE)
				take_token(EV_NEWLINE, b);
			else
				take_token(EV_DATA, b);
		end
		if (step_n > 0)
			step_out[step_n-1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			pending_tokens = {pending_tokens, step_out[i]};
	endtask

	task automatic check_result();
		res_t got;
		res_t want;
		got = '{last: m_tlast, pos: m_tdata[23:8], data: m_tdata[7:0], kind: kind_t'(m_tuser)};
		if (pending_tokens.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 200)
				$display("%0t: unexpected result kind/byte/pos/last %0d/%02h/%0d/%0b",
					$time, got.kind, got.data, got.pos, got.last);
		end else begin
			want = pending_tokens.pop_front();
			if (got.kind !== want.kind || got.data !== want.data ||
				got.pos !== want.pos || got.last !== want.last) begin
				mismatch_count++;
				if (mismatch_count <= 200)
					$display("%0t: mismatch kind/byte/pos/last expected %0d/%02h/%0d/%0b got %0d/%02h/%0d/%0b",
						$time, want.kind, want.data, want.pos, want.last,
						got.kind, got.data, got.pos, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_record();
			held_quote = 1'b0;
			pending_tokens.delete();
			mismatch_count = 0;
			outstanding    = 0;
		end else begin
			if (s_tvalid && s_tready)
				tokenize_byte(s_tdata, s_tuser[0]);
			if (m_tvalid && m_tready)
				check_result();
			outstanding = pending_tokens.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives CSV byte streams into the tokenizer: a directed opening, random
// records with quoted and unquoted fields mixed with noise, random idling
// on both channels, and a long hold of the sink.
// ----------------------------------------------------------------------------

module testbench;
	import cst_pkg::*;

	localparam logic [8:0] Q  = {1'b0, CH_QUOTE};
	localparam logic [8:0] C  = {1'b0, CH_COMMA};
	localparam logic [8:0] NL = {1'b0, CH_NEWLINE};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic [0:0]  s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	int   mismatch_count;
	int   outstanding;
	int   src_idle_pct = 0;
	int   snk_idle_pct = 0;
	int   bytes_sent   = 0;
	int   hold_left    = 0;
	logic hold_req     = 1'b0;

	always #10 clk = ~clk;

	csv_stream_tokenizer_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	csv_stream_tokenizer_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// hold off the sink for a long stretch so the block back-pressures its input
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = 400;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic offer_byte(input logic [7:0] b, input logic eoi);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= eoi;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		bytes_sent++;
	endtask

	function automatic logic [7:0] field_char();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		if (c == CH_QUOTE || c == CH_COMMA || c == CH_NEWLINE)
			c = c ^ 8'h40;
		return c;
	endfunction

	task automatic send_field();
		int len;
		int r;
		len = $urandom_range(5);
		if ($urandom_range(2) == 0) begin
			repeat (len) offer_byte(field_char(), 1'b0);
		end else begin
			offer_byte(CH_QUOTE, 1'b0);
			repeat (len) begin
				r = $urandom_range(9);
				if (r < 6) begin
					offer_byte(field_char(), 1'b0);
				end else if (r == 6) begin
					offer_byte(CH_COMMA, 1'b0);
				end else if (r == 7) begin
					offer_byte(CH_NEWLINE, 1'b0);
				end else begin
					offer_byte(CH_QUOTE, 1'b0);
					offer_byte(CH_QUOTE, 1'b0);
				end
			end
			offer_byte(CH_QUOTE, 1'b0);
		end
	endtask

	task automatic send_record();
		int nf;
		int r;
		nf = $urandom_range(1, 4);
		for (int f = 0; f < nf; f++) begin
			if (f > 0)
				offer_byte(CH_COMMA, 1'b0);
			send_field();
		end
		r = $urandom_range(19);
		if (r < 18)
			offer_byte(CH_NEWLINE, 1'b0);
		else if (r == 18)
			offer_byte(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic send_noise();
		int r;
		repeat ($urandom_range(1, 6)) begin
			r = $urandom_range(9);
			if (r < 2)
				offer_byte(CH_QUOTE, 1'b0);
			else if (r == 2)
				offer_byte(CH_COMMA, 1'b0);
			else if (r == 3)
				offer_byte(CH_NEWLINE, 1'b0);
			else if (r == 4)
				offer_byte(8'($urandom_range(255)), 1'b1);
			else
				offer_byte(8'($urandom_range(255)), 1'b0);
		end
	endtask

	task automatic send_random(input int upto);
		while (bytes_sent < upto) begin
			if ($urandom_range(99) < 15)
				send_noise();
			else
				send_record();
		end
	endtask

	initial begin
		logic [8:0] opening[] = '{
			9'h100, 9'h061, Q, 9'h062, C, 9'h000, 9'h0FF, NL, C, 9'h1FF,
			Q, 9'h078, Q, Q, Q, C, Q, Q, 9'h100,
			Q, Q, 9'h07A, Q, Q, Q, 9'h071, Q, Q, NL, Q, 9'h1A5
		};
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct = 13;
		snk_idle_pct = 85;
		foreach (opening[i])
			offer_byte(opening[i][7:0], opening[i][8]);
		send_random(380);

		src_idle_pct = 85;
		snk_idle_pct = 13;
		send_random(720);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_req = 1'b1;
		send_random(1045);

		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#10ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
